[rtl/core/bls_pkg.sv]
// Shared types and constants for the Bresenham line stepper.
package bls_pkg;

  // Default coordinate width; the top level exposes it as a parameter.
  localparam int COORD_BITS_DEF = 13;

  // Configuration register width, reset value and bus widths.
  localparam int REG_BITS = 13;
  localparam logic [REG_BITS-1:0] IMAGE_SIZE_RESET = 13'd500;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Register index, taken from the word address bit of paddr.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Color width.
  localparam int COLOR_BITS = 24;

  // Request kinds.
  typedef enum logic {
    REQ_START   = 1'b0,
    REQ_ADVANCE = 1'b1
  } req_type_e;

  // Per-pixel status flags handed from the step logic to the result register.
  typedef struct packed {
    logic pixel_valid;
    logic in_bounds;
    logic last_pixel;
  } pix_flags_t;

endpackage

[rtl/core/bls_cfg.sv]
// APB-style configuration registers for the image width and height.
module bls_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bls_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bls_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bls_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [bls_pkg::REG_BITS-1:0]      image_width_o,
  output logic [bls_pkg::REG_BITS-1:0]      image_height_o
);
  import bls_pkg::*;

  logic                wr_en;
  logic                reg_idx;
  logic [REG_BITS-1:0] width_q, width_d;
  logic [REG_BITS-1:0] height_q, height_d;

  // The register index is the word address; the byte offset bits are ignored.
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Next register values on a completed write.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (reg_idx)
        CFG_IDX_WIDTH:  width_d  = pwdata[REG_BITS-1:0];
        CFG_IDX_HEIGHT: height_d = pwdata[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMAGE_SIZE_RESET;
      height_q <= IMAGE_SIZE_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  // Read data, zero extended to the bus width.
  always_comb begin
    case (reg_idx)
      CFG_IDX_WIDTH:  prdata = APB_DATA_W'(width_q);
      CFG_IDX_HEIGHT: prdata = APB_DATA_W'(height_q);
      default:        prdata = '0;
    endcase
  end

  assign image_width_o  = width_q;
  assign image_height_o = height_q;

endmodule

[rtl/core/bls_in_reg.sv]
// Input register stage that holds one request until the step logic takes it.
module bls_in_reg #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [COORD_BITS-1:0]      x_start_i,
  input  logic signed [COORD_BITS-1:0]      y_start_i,
  input  logic signed [COORD_BITS-1:0]      x_end_i,
  input  logic signed [COORD_BITS-1:0]      y_end_i,
  input  logic [bls_pkg::COLOR_BITS-1:0]    line_color_i,
  input  logic                              take_i,
  output logic                              valid_o,
  output logic                              req_type_o,
  output logic signed [COORD_BITS-1:0]      x_start_o,
  output logic signed [COORD_BITS-1:0]      y_start_o,
  output logic signed [COORD_BITS-1:0]      x_end_o,
  output logic signed [COORD_BITS-1:0]      y_end_o,
  output logic [bls_pkg::COLOR_BITS-1:0]    line_color_o
);
  import bls_pkg::*;

  logic                          valid_q, valid_d;
  logic                          load;
  logic                          req_type_q;
  logic signed [COORD_BITS-1:0]  x_start_q, y_start_q, x_end_q, y_end_q;
  logic [COLOR_BITS-1:0]         color_q;

  // The stage accepts a request when empty or when its content moves on.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload registers load only with a request.
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_type_q <= req_type_i;
      x_start_q  <= x_start_i;
      y_start_q  <= y_start_i;
      x_end_q    <= x_end_i;
      y_end_q    <= y_end_i;
      color_q    <= line_color_i;
    end
  end

  assign valid_o      = valid_q;
  assign req_type_o   = req_type_q;
  assign x_start_o    = x_start_q;
  assign y_start_o    = y_start_q;
  assign x_end_o      = x_end_q;
  assign y_end_o      = y_end_q;
  assign line_color_o = color_q;

endmodule

[rtl/core/bls_step.sv]
// Bresenham stepper state and the per-request setup and step logic.
module bls_step #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  input  logic                              req_type_i,
  input  logic signed [COORD_BITS-1:0]      x_start_i,
  input  logic signed [COORD_BITS-1:0]      y_start_i,
  input  logic signed [COORD_BITS-1:0]      x_end_i,
  input  logic signed [COORD_BITS-1:0]      y_end_i,
  input  logic [bls_pkg::COLOR_BITS-1:0]    line_color_i,
  input  logic [bls_pkg::REG_BITS-1:0]      image_width_i,
  input  logic [bls_pkg::REG_BITS-1:0]      image_height_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [bls_pkg::COLOR_BITS-1:0]    pixel_color_o,
  output bls_pkg::pix_flags_t               flags_o
);
  import bls_pkg::*;

  localparam int ERR_W = COORD_BITS + 3;
  localparam int CMP_W = ((COORD_BITS > REG_BITS) ? COORD_BITS : REG_BITS) + 1;

  // Stepper state.
  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [ERR_W-1:0]      err_q, err_d;
  logic [1:0]                   step_x_q, step_x_d, step_y_q, step_y_d;
  logic [COORD_BITS-1:0]        major_q, major_d, minor_q, minor_d;
  logic                         x_major_q, x_major_d;
  logic [COORD_BITS-1:0]        left_q, left_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;
  logic                         active_q, active_d;

  // Setup values of a start request.
  logic                         is_start;
  logic signed [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0]        adx, ady;
  logic [1:0]                   sx_new, sy_new;
  logic                         x_major_new;
  logic [COORD_BITS-1:0]        major_new, minor_new;
  logic signed [ERR_W-1:0]      err_new;

  // Effective values: the freshly set-up line on a start, else the state.
  logic signed [COORD_BITS-1:0] e_x, e_y;
  logic signed [ERR_W-1:0]      e_err;
  logic [1:0]                   e_sx, e_sy;
  logic [COORD_BITS-1:0]        e_major, e_minor, e_left;
  logic                         e_x_major;
  logic [COLOR_BITS-1:0]        e_color;
  logic                         e_active;

  // Step results.
  logic                         is_last;
  logic                         minor_neg;
  logic                         err_ge;
  logic                         move_x, move_y;
  logic signed [ERR_W-1:0]      major2, minor2;
  logic signed [ERR_W-1:0]      err_nx;
  logic signed [COORD_BITS-1:0] x_nx, y_nx;
  logic                         x_inside, y_inside;

  assign is_start = (req_type_i == REQ_START);

  // Line setup: deltas, magnitudes, directions and the initial error.
  always_comb begin
    dx  = {x_end_i[COORD_BITS-1], x_end_i} - {x_start_i[COORD_BITS-1], x_start_i};
    dy  = {y_end_i[COORD_BITS-1], y_end_i} - {y_start_i[COORD_BITS-1], y_start_i};
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    sx_new = (dx == '0) ? 2'b00 : (dx[COORD_BITS] ? 2'b11 : 2'b01);
    sy_new = (dy == '0) ? 2'b00 : (dy[COORD_BITS] ? 2'b11 : 2'b01);
    x_major_new = (adx >= ady);
    major_new   = x_major_new ? adx : ady;
    minor_new   = x_major_new ? ady : adx;
    err_new     = $signed({2'b00, minor_new, 1'b0}) - $signed({3'b000, major_new});
  end

  // Select the set-up line or the stored one.
  always_comb begin
    if (is_start) begin
      e_x       = x_start_i;
      e_y       = y_start_i;
      e_err     = err_new;
      e_sx      = sx_new;
      e_sy      = sy_new;
      e_major   = major_new;
      e_minor   = minor_new;
      e_left    = major_new;
      e_x_major = x_major_new;
      e_color   = line_color_i;
      e_active  = 1'b1;
    end else begin
      e_x       = cur_x_q;
      e_y       = cur_y_q;
      e_err     = err_q;
      e_sx      = step_x_q;
      e_sy      = step_y_q;
      e_major   = major_q;
      e_minor   = minor_q;
      e_left    = left_q;
      e_x_major = x_major_q;
      e_color   = color_q;
      e_active  = active_q;
    end
  end

  // One Bresenham step; the minor axis moves at error >= 1 when it runs negative.
  always_comb begin
    is_last   = (e_left == '0);
    minor_neg = e_x_major ? e_sy[1] : e_sx[1];
    err_ge    = minor_neg ? (!e_err[ERR_W-1] && (e_err != '0)) : !e_err[ERR_W-1];
    major2    = $signed({2'b00, e_major, 1'b0});
    minor2    = $signed({2'b00, e_minor, 1'b0});
    err_nx    = e_err - (err_ge ? major2 : ERR_W'(0)) + minor2;
    move_x    = e_x_major || err_ge;
    move_y    = !e_x_major || err_ge;
    x_nx      = move_x ? (e_x + {{(COORD_BITS-2){e_sx[1]}}, e_sx}) : e_x;
    y_nx      = move_y ? (e_y + {{(COORD_BITS-2){e_sy[1]}}, e_sy}) : e_y;
  end

  // Next state, updated only when a request passes through.
  always_comb begin
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    err_d     = err_q;
    step_x_d  = step_x_q;
    step_y_d  = step_y_q;
    major_d   = major_q;
    minor_d   = minor_q;
    x_major_d = x_major_q;
    left_d    = left_q;
    color_d   = color_q;
    active_d  = active_q;
    if (fire_i && e_active) begin
      step_x_d  = e_sx;
      step_y_d  = e_sy;
      major_d   = e_major;
      minor_d   = e_minor;
      x_major_d = e_x_major;
      color_d   = e_color;
      if (is_last) begin
        cur_x_d  = e_x;
        cur_y_d  = e_y;
        err_d    = e_err;
        left_d   = e_left;
        active_d = 1'b0;
      end else begin
        cur_x_d  = x_nx;
        cur_y_d  = y_nx;
        err_d    = err_nx;
        left_d   = e_left - 1'b1;
        active_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      err_q     <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
      major_q   <= '0;
      minor_q   <= '0;
      x_major_q <= 1'b0;
      left_q    <= '0;
      color_q   <= '0;
      active_q  <= 1'b0;
    end else begin
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      err_q     <= err_d;
      step_x_q  <= step_x_d;
      step_y_q  <= step_y_d;
      major_q   <= major_d;
      minor_q   <= minor_d;
      x_major_q <= x_major_d;
      left_q    <= left_d;
      color_q   <= color_d;
      active_q  <= active_d;
    end
  end

  // Bounds check against the configured image size.
  assign x_inside = !e_x[COORD_BITS-1] &&
                    ({{(CMP_W-COORD_BITS){1'b0}}, e_x} < CMP_W'(image_width_i));
  assign y_inside = !e_y[COORD_BITS-1] &&
                    ({{(CMP_W-COORD_BITS){1'b0}}, e_y} < CMP_W'(image_height_i));

  // Result of the request; all zero when no line is active.
  always_comb begin
    pixel_x_o           = e_active ? e_x : '0;
    pixel_y_o           = e_active ? e_y : '0;
    pixel_color_o       = e_active ? e_color : '0;
    flags_o.pixel_valid = e_active;
    flags_o.in_bounds   = e_active && x_inside && y_inside;
    flags_o.last_pixel  = e_active && is_last;
  end

endmodule

[rtl/core/bls_out_reg.sv]
// Result register that holds one pixel until the consumer takes it.
module bls_out_reg #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              fire_i,
  output logic                              free_o,
  input  logic signed [COORD_BITS-1:0]      pixel_x_i,
  input  logic signed [COORD_BITS-1:0]      pixel_y_i,
  input  logic [bls_pkg::COLOR_BITS-1:0]    pixel_color_i,
  input  bls_pkg::pix_flags_t               flags_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [bls_pkg::COLOR_BITS-1:0]    pixel_color_o,
  output bls_pkg::pix_flags_t               flags_o
);
  import bls_pkg::*;

  logic                         valid_q, valid_d;
  logic signed [COORD_BITS-1:0] x_q, y_q;
  logic [COLOR_BITS-1:0]        color_q;
  pix_flags_t                   flags_q;

  // The register can take a new result when empty or being drained.
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (fire_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      x_q     <= pixel_x_i;
      y_q     <= pixel_y_i;
      color_q <= pixel_color_i;
      flags_q <= flags_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q;
  assign pixel_color_o = color_q;
  assign flags_o       = flags_q;

endmodule

[rtl/core/bresenham_line_stepper.sv]
// Bresenham line stepper, all octants: a start request sets up a line and returns
// its first pixel, each advance request returns the next pixel, one result per
// request, each flagged in_bounds against the configured image size and
// last_pixel at the second endpoint; an advance while idle returns a result with
// pixel_valid low and all other fields zero. The block takes one request every
// clock and returns one pixel every clock while the pixel port does not stall.
// A request goes through the input register, then the result register, to the
// pixel port; a stalled pixel port holds the result and then the input register,
// after which the request side stalls. The step logic between the two registers
// updates the line state once per request, which sets that rate. Image width and
// height are written over the APB port at 0x0 and 0x4.
module bresenham_line_stepper #(
  parameter int COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bls_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [bls_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [bls_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic signed [COORD_BITS-1:0]      x_start_i,
  input  logic signed [COORD_BITS-1:0]      y_start_i,
  input  logic signed [COORD_BITS-1:0]      x_end_i,
  input  logic signed [COORD_BITS-1:0]      y_end_i,
  input  logic [bls_pkg::COLOR_BITS-1:0]    line_color_i,
  // Pixel channel.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      pixel_x_o,
  output logic signed [COORD_BITS-1:0]      pixel_y_o,
  output logic [bls_pkg::COLOR_BITS-1:0]    pixel_color_o,
  output logic                              pixel_valid_o,
  output logic                              in_bounds_o,
  output logic                              last_pixel_o
);
  import bls_pkg::*;

  logic [REG_BITS-1:0]          image_width;
  logic [REG_BITS-1:0]          image_height;
  logic                         s1_valid;
  logic                         s1_req_type;
  logic signed [COORD_BITS-1:0] s1_x_start, s1_y_start, s1_x_end, s1_y_end;
  logic [COLOR_BITS-1:0]        s1_color;
  logic                         out_free;
  logic                         fire;
  logic signed [COORD_BITS-1:0] st_x, st_y;
  logic [COLOR_BITS-1:0]        st_color;
  pix_flags_t                   st_flags;
  pix_flags_t                   out_flags;

  // A request moves from the input register into the result register.
  assign fire = s1_valid && out_free;

  bls_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .image_width_o  (image_width),
    .image_height_o (image_height)
  );

  bls_in_reg #(.COORD_BITS(COORD_BITS)) u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .x_start_i    (x_start_i),
    .y_start_i    (y_start_i),
    .x_end_i      (x_end_i),
    .y_end_i      (y_end_i),
    .line_color_i (line_color_i),
    .take_i       (out_free),
    .valid_o      (s1_valid),
    .req_type_o   (s1_req_type),
    .x_start_o    (s1_x_start),
    .y_start_o    (s1_y_start),
    .x_end_o      (s1_x_end),
    .y_end_o      (s1_y_end),
    .line_color_o (s1_color)
  );

  bls_step #(.COORD_BITS(COORD_BITS)) u_step (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .req_type_i     (s1_req_type),
    .x_start_i      (s1_x_start),
    .y_start_i      (s1_y_start),
    .x_end_i        (s1_x_end),
    .y_end_i        (s1_y_end),
    .line_color_i   (s1_color),
    .image_width_i  (image_width),
    .image_height_i (image_height),
    .pixel_x_o      (st_x),
    .pixel_y_o      (st_y),
    .pixel_color_o  (st_color),
    .flags_o        (st_flags)
  );

  bls_out_reg #(.COORD_BITS(COORD_BITS)) u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .free_o        (out_free),
    .pixel_x_i     (st_x),
    .pixel_y_i     (st_y),
    .pixel_color_i (st_color),
    .flags_i       (st_flags),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .flags_o       (out_flags)
  );

  assign pixel_valid_o = out_flags.pixel_valid;
  assign in_bounds_o   = out_flags.in_bounds;
  assign last_pixel_o  = out_flags.last_pixel;

  // An empty result register never holds back the request side.
  a_no_stall_when_empty: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o
  ) else $error("request side stalled while the result register is empty");

  // An in-bounds pixel has non-negative coordinates and is a real pixel.
  a_in_bounds_coords: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_bounds_o) |->
      (pixel_valid_o && !pixel_x_o[COORD_BITS-1] && !pixel_y_o[COORD_BITS-1])
  ) else $error("in-bounds pixel with negative coordinate or no pixel");

  // The image width changes only through a configuration write.
  a_width_only_by_write: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !(psel && penable && pwrite) |=> $stable(image_width)
  ) else $error("image width changed without a configuration write");

endmodule
